// File: hdl/mhdm_pkg.sv
// Shared types, microcode fields and control store for the heap delete-max unit.
package mhdm_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Sequencer steps (control store addresses)
  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_RD_ROOT  = 3'd1,
    S_RD_LAST  = 3'd2,
    S_CAP_LAST = 3'd3,
    S_LOOP     = 3'd4,
    S_RD_RIGHT = 3'd5,
    S_DECIDE   = 3'd6,
    S_DONE     = 3'd7
  } step_e;

  // Read address source
  typedef enum logic [2:0] {
    RD_NONE  = 3'd0,
    RD_ROOT  = 3'd1,
    RD_LAST  = 3'd2,
    RD_LEFT  = 3'd3,
    RD_RIGHT = 3'd4
  } rd_e;

  // Which register takes the read data
  typedef enum logic [1:0] {
    CAP_NONE = 2'd0,
    CAP_MAX  = 2'd1,
    CAP_X    = 2'd2,
    CAP_LEFT = 2'd3
  } cap_e;

  // Store write action
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_LEAF = 2'd1,
    WR_SIFT = 2'd2
  } wr_e;

  // Branch condition
  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_START    = 3'd1,
    C_LEAF     = 3'd2,
    C_SWAP     = 3'd3,
    C_OUT_FREE = 3'd4
  } cond_e;

  // What to do when the branch is not taken
  typedef enum logic {
    M_FALL = 1'b0,
    M_HOLD = 1'b1
  } miss_e;

  // One control word
  typedef struct packed {
    rd_e   rd;
    cap_e  cap;
    wr_e   wr;
    logic  dec;     // shrink heap, restart sift at the root
    logic  push;    // hand the delete result to the output register
    cond_e cond;
    miss_e miss;
    step_e target;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    ucode_t uc;
    logic   fire;   // input item accepted this cycle
  } ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic empty;
    logic full;
    logic leaf;
    logic swap;
    logic out_free;
  } flags_t;

  // Control store
  function automatic ucode_t ucode_rom(step_e step);
    ucode_t w;
    w = '{rd: RD_NONE, cap: CAP_NONE, wr: WR_NONE, dec: 1'b0, push: 1'b0,
          cond: C_START, miss: M_HOLD, target: S_RD_ROOT};
    case (step)
      S_IDLE: begin
        w = '{rd: RD_NONE, cap: CAP_NONE, wr: WR_NONE, dec: 1'b0, push: 1'b0,
              cond: C_START, miss: M_HOLD, target: S_RD_ROOT};
      end
      S_RD_ROOT: begin
        w = '{rd: RD_ROOT, cap: CAP_NONE, wr: WR_NONE, dec: 1'b1, push: 1'b0,
              cond: C_ALWAYS, miss: M_FALL, target: S_RD_LAST};
      end
      S_RD_LAST: begin
        w = '{rd: RD_LAST, cap: CAP_MAX, wr: WR_NONE, dec: 1'b0, push: 1'b0,
              cond: C_ALWAYS, miss: M_FALL, target: S_CAP_LAST};
      end
      S_CAP_LAST: begin
        w = '{rd: RD_NONE, cap: CAP_X, wr: WR_NONE, dec: 1'b0, push: 1'b0,
              cond: C_ALWAYS, miss: M_FALL, target: S_LOOP};
      end
      S_LOOP: begin
        w = '{rd: RD_LEFT, cap: CAP_NONE, wr: WR_LEAF, dec: 1'b0, push: 1'b0,
              cond: C_LEAF, miss: M_FALL, target: S_DONE};
      end
      S_RD_RIGHT: begin
        w = '{rd: RD_RIGHT, cap: CAP_LEFT, wr: WR_NONE, dec: 1'b0, push: 1'b0,
              cond: C_ALWAYS, miss: M_FALL, target: S_DECIDE};
      end
      S_DECIDE: begin
        w = '{rd: RD_NONE, cap: CAP_NONE, wr: WR_SIFT, dec: 1'b0, push: 1'b0,
              cond: C_SWAP, miss: M_FALL, target: S_LOOP};
      end
      S_DONE: begin
        w = '{rd: RD_NONE, cap: CAP_NONE, wr: WR_NONE, dec: 1'b0, push: 1'b1,
              cond: C_OUT_FREE, miss: M_HOLD, target: S_IDLE};
      end
      default: begin
        w = '{rd: RD_NONE, cap: CAP_NONE, wr: WR_NONE, dec: 1'b0, push: 1'b0,
              cond: C_ALWAYS, miss: M_FALL, target: S_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage

// File: hdl/mhdm_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
module mhdm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                op_i,
  input  mhdm_pkg::flags_t    flags_i,
  output logic                in_stall_o,
  output mhdm_pkg::ctl_t      ctl_o
);

  mhdm_pkg::step_e  step_q, step_d;
  mhdm_pkg::ucode_t uc;
  logic             fire;
  logic             taken;

  // Current control word
  assign uc = mhdm_pkg::ucode_rom(step_q);

  // Handshake and control outputs
  always_comb begin
    in_stall_o = (step_q != mhdm_pkg::S_IDLE) || !flags_i.out_free;
    fire       = in_valid_i && !in_stall_o;
    ctl_o.uc   = uc;
    ctl_o.fire = fire;
  end

  // Branch condition and next step
  always_comb begin
    case (uc.cond)
      mhdm_pkg::C_ALWAYS:   taken = 1'b1;
      mhdm_pkg::C_START:    taken = fire && op_i && !flags_i.empty;
      mhdm_pkg::C_LEAF:     taken = flags_i.leaf;
      mhdm_pkg::C_SWAP:     taken = flags_i.swap;
      mhdm_pkg::C_OUT_FREE: taken = flags_i.out_free;
      default:              taken = 1'b1;
    endcase
    if (taken) begin
      step_d = uc.target;
    end else if (uc.miss == mhdm_pkg::M_HOLD) begin
      step_d = step_q;
    end else begin
      step_d = mhdm_pkg::step_e'(3'(step_q) + 3'd1);
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= mhdm_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: hdl/mhdm_dp.sv
// Heap datapath: element store, count, sift registers and result register.
module mhdm_dp #(
  parameter int unsigned HEAP_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mhdm_pkg::ctl_t      ctl_i,
  input  logic                op_i,
  input  logic signed [31:0]  load_value_i,
  input  logic                out_stall_i,
  output mhdm_pkg::flags_t    flags_o,
  output logic                out_valid_o,
  output logic signed [31:0]  removed_max_o,
  output logic [1:0]          status_o
);

  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);  // count width
  localparam int unsigned PW = CW + 1;                  // heap position width
  localparam int unsigned AW = $clog2(HEAP_DEPTH);      // store address width

  logic signed [31:0] mem [HEAP_DEPTH];
  logic signed [31:0] rdata_q;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  logic [CW-1:0]      cnt_q, cnt_d;
  logic [PW-1:0]      i_q, i_d;
  logic signed [31:0] x_q, c_q, max_q;

  logic [PW-1:0]      j, jr, jm1, im1, n_ext;
  logic               has_right, leaf, right_gt, swap;
  logic signed [31:0] pick;
  logic [PW-1:0]      pick_pos;

  logic                    out_valid_q;
  logic signed [31:0]      out_removed_q;
  mhdm_pkg::status_e       out_status_q;
  logic                    out_free, ld_ok, push_now;
  logic signed [31:0]      push_removed;
  mhdm_pkg::status_e       push_status;

  // Child positions of the current sift position
  always_comb begin
    n_ext     = {1'b0, cnt_q};
    j         = {i_q[PW-2:0], 1'b0};
    jr        = j + PW'(1);
    jm1       = j - PW'(1);
    im1       = i_q - PW'(1);
    leaf      = j > n_ext;
    has_right = jr <= n_ext;
  end

  // Larger child against the moving element
  always_comb begin
    right_gt = has_right && (rdata_q > c_q);
    pick     = right_gt ? rdata_q : c_q;
    pick_pos = right_gt ? jr : j;
    swap     = (ctl_i.uc.wr == mhdm_pkg::WR_SIFT) && (pick > x_q);
  end

  // Status to the sequencer
  assign out_free = !out_valid_q || !out_stall_i;
  always_comb begin
    flags_o.empty    = (cnt_q == '0);
    flags_o.full     = (cnt_q == CW'(HEAP_DEPTH));
    flags_o.leaf     = leaf;
    flags_o.swap     = swap;
    flags_o.out_free = out_free;
  end

  // Read address
  always_comb begin
    case (ctl_i.uc.rd)
      mhdm_pkg::RD_ROOT:  rd_addr = '0;
      mhdm_pkg::RD_LAST:  rd_addr = cnt_q[AW-1:0];
      mhdm_pkg::RD_LEFT:  rd_addr = jm1[AW-1:0];
      mhdm_pkg::RD_RIGHT: rd_addr = j[AW-1:0];
      default:            rd_addr = '0;
    endcase
  end

  // Write port: load append, leaf placement or sift step
  assign ld_ok = ctl_i.fire && !op_i && !flags_o.full;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = im1[AW-1:0];
    wr_data = x_q;
    if (ld_ok) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[AW-1:0];
      wr_data = load_value_i;
    end else if (ctl_i.uc.wr == mhdm_pkg::WR_LEAF) begin
      wr_en   = leaf;
    end else if (ctl_i.uc.wr == mhdm_pkg::WR_SIFT) begin
      wr_en   = 1'b1;
      wr_data = swap ? pick : x_q;
    end
  end

  // Element store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // Count and sift position
  always_comb begin
    cnt_d = cnt_q;
    i_d   = i_q;
    if (ld_ok) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (ctl_i.uc.dec) begin
      cnt_d = cnt_q - CW'(1);
      i_d   = PW'(1);
    end
    if (swap) begin
      i_d = pick_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      i_q   <= PW'(1);
    end else begin
      cnt_q <= cnt_d;
      i_q   <= i_d;
    end
  end

  // Captures from the read port
  always_ff @(posedge clk_i) begin
    case (ctl_i.uc.cap)
      mhdm_pkg::CAP_MAX:  max_q <= rdata_q;
      mhdm_pkg::CAP_X:    x_q   <= rdata_q;
      mhdm_pkg::CAP_LEFT: c_q   <= rdata_q;
      default: ;
    endcase
  end

  // Result selection: immediate for loads and errors, delete at the end
  always_comb begin
    push_now     = 1'b0;
    push_removed = '0;
    push_status  = mhdm_pkg::ST_OK;
    if (ctl_i.fire && !op_i) begin
      push_now    = 1'b1;
      push_status = flags_o.full ? mhdm_pkg::ST_FULL : mhdm_pkg::ST_OK;
    end else if (ctl_i.fire && op_i && flags_o.empty) begin
      push_now    = 1'b1;
      push_status = mhdm_pkg::ST_EMPTY;
    end else if (ctl_i.uc.push && out_free) begin
      push_now     = 1'b1;
      push_removed = max_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_now) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_now) begin
      out_removed_q <= push_removed;
      out_status_q  <= push_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign removed_max_o = out_removed_q;
  assign status_o      = 2'(out_status_q);

`ifndef SYNTHESIS
  // Element count stays within the store
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(HEAP_DEPTH))
    else $error("element count beyond heap depth");

  // Error results never carry a value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != mhdm_pkg::ST_OK)) |-> (out_removed_q == '0))
    else $error("error result with nonzero value");

  // A sift swap always moves the position down the tree
  a_sift_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swap |=> (i_q > $past(i_q)))
    else $error("sift position did not advance");

  // A result is never overwritten while it is stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !push_now)
    else $error("stalled result overwritten");
`endif

endmodule

// File: hdl/max_heap_delete_max_unit.sv
// Top level of the binary max heap with load and delete-max items.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    op_i, load_value_i
//   out      output     out_valid_o / out_stall_i  removed_max_o, status_o
//
// A load or an error item is answered at once: its result is written to the
// output register as the item is accepted. A delete walks the microcode: the
// accepting idle step, three setup steps (root read, last read, capture), then
// three steps per level swapped (left read, right read, compare and write), one
// or three steps to stop and one to hand off the result, which holds while the
// output is stalled; the steps follow the single read port of the element store.
// Reset clears the count and the sequencer; the store needs no clearing pass.
// Input is stalled while a delete is in progress and while a finished result
// is stalled.
module max_heap_delete_max_unit #(
  parameter int unsigned HEAP_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic signed [31:0] load_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] removed_max_o,
  output logic [1:0]         status_o
);

  mhdm_pkg::ctl_t   ctl;
  mhdm_pkg::flags_t flags;

  // Control sequencer
  mhdm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .flags_i    (flags),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  // Heap datapath
  mhdm_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .op_i          (op_i),
    .load_value_i  (load_value_i),
    .out_stall_i   (out_stall_i),
    .flags_o       (flags),
    .out_valid_o   (out_valid_o),
    .removed_max_o (removed_max_o),
    .status_o      (status_o)
  );

endmodule
